@@ rtl/depth_pixel_to_world_point_macros.svh @@
// ----------------------------------------------------------------------------
// depth_pixel_to_world_point assertion macros
// Shared concurrent assertion forms for the back-projection block.
// ----------------------------------------------------------------------------
`ifndef DEPTH_PIXEL_TO_WORLD_POINT_MACROS_SVH
`define DEPTH_PIXEL_TO_WORLD_POINT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define DPW_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define DPW_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/dpw_pkg.sv @@
// ----------------------------------------------------------------------------
// dpw_pkg
// Types, register indexes and helpers for the depth back-projection block.
// ----------------------------------------------------------------------------
package dpw_pkg;

   typedef logic [8:0]          column_type;
   typedef logic [7:0]          row_type;
   typedef logic signed [15:0]  depth_type;
   typedef logic signed [31:0]  point_type;
   typedef logic [2:0]          csr_index_type;
   typedef logic [63:0]         csr_data_type;
   typedef logic [62:0]         triple_type;
   typedef logic signed [20:0]  coef_type;
   typedef logic signed [39:0]  diff_type;
   typedef logic signed [60:0]  term_type;

   localparam int FIELD_W = 21;

   localparam csr_index_type CSR_INV_DEPTH_SCALE = 3'd0;
   localparam csr_index_type CSR_INV_FOCAL_PAIR  = 3'd1;
   localparam csr_index_type CSR_PRINCIPAL_POINT = 3'd2;
   localparam csr_index_type CSR_ROT_ROW_X       = 3'd3;
   localparam csr_index_type CSR_ROT_ROW_Y       = 3'd4;
   localparam csr_index_type CSR_ROT_ROW_Z       = 3'd5;
   localparam csr_index_type CSR_TRANSLATION     = 3'd6;

   localparam logic [31:0] INV_DEPTH_SCALE_RESET = 32'hFFFF_FFFF;

   // Pull one signed 21-bit field out of a packed triple.
   function automatic coef_type field21(triple_type word_val, int k);
      return coef_type'(word_val[FIELD_W*k +: FIELD_W]);
   endfunction

endpackage

@@ rtl/dpw_channels.sv @@
// ----------------------------------------------------------------------------
// dpw channels
// Valid/ready channel interfaces for pixel requests, points and CSR writes.
// ----------------------------------------------------------------------------
interface dpw_req_if;
   logic                valid;
   logic                ready;
   dpw_pkg::column_type column;
   dpw_pkg::row_type    row;
   dpw_pkg::depth_type  depth;

   modport source (output valid, output column, output row, output depth, input ready);
   modport sink   (input valid, input column, input row, input depth, output ready);
endinterface

interface dpw_rsp_if;
   logic               valid;
   logic               ready;
   dpw_pkg::point_type point_x;
   dpw_pkg::point_type point_y;
   dpw_pkg::point_type point_z;

   modport source (output valid, output point_x, output point_y, output point_z, input ready);
   modport sink   (input valid, input point_x, input point_y, input point_z, output ready);
endinterface

interface dpw_csr_if;
   logic                   valid;
   logic                   ready;
   dpw_pkg::csr_index_type index;
   dpw_pkg::csr_data_type  data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

@@ rtl/depth_pixel_to_world_point.sv @@
// ----------------------------------------------------------------------------
// depth_pixel_to_world_point
// Pinhole back-projection of depth pixels to transformed Q15.16 points.
// ----------------------------------------------------------------------------
// Usage:
//   req_chan carries one depth pixel per request (column, row, raw depth).
//   Pixels with depth zero or below, or outside IMAGE_WIDTH x IMAGE_HEIGHT,
//   are consumed and give no point. Every other request gives one point
//   (point_x, point_y, point_z, signed Q15.16, saturated) on rsp_chan.
//   csr_chan writes the seven calibration registers by index; it is always
//   ready, a write takes effect at the next edge, unknown indexes are dropped.
//   Write calibration only while no request is in flight.
// Timing:
//   Six register stages: multiply depth and center offsets, project by z,
//   scale by 1/f in two 16-bit partial products, subtract translation and
//   clamp, nine coefficient products, sum/round/saturate into the output
//   register. Throughput is one request per cycle while rsp_chan accepts
//   points, set by the single pass through these stages.
//   Each stage holds its own valid bit, so a stalled output only blocks the
//   requests behind it once every stage is full; empty stages keep filling.
// Reset:
//   Clears all stage valid bits and loads the register defaults (depth scale
//   all ones, everything else zero). No clearing pass.
// ----------------------------------------------------------------------------
`include "depth_pixel_to_world_point_macros.svh"

module depth_pixel_to_world_point #(
   parameter int unsigned IMAGE_WIDTH  = 346,
   parameter int unsigned IMAGE_HEIGHT = 240
) (
   input  logic       clock,
   input  logic       reset,
   dpw_req_if.sink    req_chan,
   dpw_rsp_if.source  rsp_chan,
   dpw_csr_if.sink    csr_chan
);

   localparam int STAGES = 6;

   // ------------------------------------------------------------------
   // Calibration registers
   // ------------------------------------------------------------------
   logic [31:0]         inv_depth_scale_ff, inv_depth_scale_in;
   logic [63:0]         inv_focal_pair_ff, inv_focal_pair_in;
   logic [63:0]         principal_point_ff, principal_point_in;
   dpw_pkg::triple_type rot_ff [3];
   dpw_pkg::triple_type rot_in [3];
   dpw_pkg::triple_type translation_ff, translation_in;

   assign csr_chan.ready = 1'b1;

   always_comb begin
      inv_depth_scale_in = inv_depth_scale_ff;
      inv_focal_pair_in  = inv_focal_pair_ff;
      principal_point_in = principal_point_ff;
      rot_in             = rot_ff;
      translation_in     = translation_ff;
      if (csr_chan.valid && csr_chan.ready) begin
         case (csr_chan.index)
            dpw_pkg::CSR_INV_DEPTH_SCALE: inv_depth_scale_in = csr_chan.data[31:0];
            dpw_pkg::CSR_INV_FOCAL_PAIR:  inv_focal_pair_in  = csr_chan.data;
            dpw_pkg::CSR_PRINCIPAL_POINT: principal_point_in = csr_chan.data;
            dpw_pkg::CSR_ROT_ROW_X:       rot_in[0]          = csr_chan.data[62:0];
            dpw_pkg::CSR_ROT_ROW_Y:       rot_in[1]          = csr_chan.data[62:0];
            dpw_pkg::CSR_ROT_ROW_Z:       rot_in[2]          = csr_chan.data[62:0];
            dpw_pkg::CSR_TRANSLATION:     translation_in     = csr_chan.data[62:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         inv_depth_scale_ff <= dpw_pkg::INV_DEPTH_SCALE_RESET;
         inv_focal_pair_ff  <= '0;
         principal_point_ff <= '0;
         rot_ff             <= '{default: '0};
         translation_ff     <= '0;
      end else begin
         inv_depth_scale_ff <= inv_depth_scale_in;
         inv_focal_pair_ff  <= inv_focal_pair_in;
         principal_point_ff <= principal_point_in;
         rot_ff             <= rot_in;
         translation_ff     <= translation_in;
      end
   end

   // ------------------------------------------------------------------
   // Stage valid bits and ready chain
   // ------------------------------------------------------------------
   logic [STAGES:1] valid_ff, valid_in;
   logic [STAGES:1] stage_rdy;
   logic            pix_ok;

   always_comb begin
      stage_rdy[STAGES] = !valid_ff[STAGES] || rsp_chan.ready;
      for (int k = STAGES - 1; k >= 1; k--) begin
         stage_rdy[k] = !valid_ff[k] || stage_rdy[k+1];
      end
   end

   assign req_chan.ready = stage_rdy[1];

   assign pix_ok = (req_chan.depth > 16'sd0)
                && (32'(req_chan.column) < IMAGE_WIDTH)
                && (32'(req_chan.row) < IMAGE_HEIGHT);

   always_comb begin
      valid_in[1] = req_chan.valid && pix_ok;
      for (int k = 2; k <= STAGES; k++) begin
         valid_in[k] = valid_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int k = 1; k <= STAGES; k++) begin
            if (stage_rdy[k]) begin
               valid_ff[k] <= valid_in[k];
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Stage 1: raw z product and center offsets
   // ------------------------------------------------------------------
   logic [46:0]        zprod_ff, zprod_in;
   logic signed [33:0] du_ff, du_in, dv_ff, dv_in;

   always_comb begin
      zprod_in = 47'(req_chan.depth[14:0]) * 47'(inv_depth_scale_ff);
      du_in    = $signed({9'd0, req_chan.column, 16'd0})
               - $signed({2'd0, principal_point_ff[31:0]});
      dv_in    = $signed({10'd0, req_chan.row, 16'd0})
               - $signed({2'd0, principal_point_ff[63:32]});
   end

   always_ff @(posedge clock) begin
      if (stage_rdy[1]) begin
         zprod_ff <= zprod_in;
         du_ff    <= du_in;
         dv_ff    <= dv_in;
      end
   end

   // ------------------------------------------------------------------
   // Stage 2: round z, offsets times z
   // ------------------------------------------------------------------
   logic [46:0]        zsum;
   logic [30:0]        z2_ff, z2_in;
   logic signed [31:0] z_signed;
   logic signed [63:0] px_ff, px_in, py_ff, py_in;

   always_comb begin
      zsum     = zprod_ff + 47'd32768;
      z2_in    = zsum[46:16];
      z_signed = $signed({1'b0, z2_in});
      px_in    = 64'(du_ff) * 64'(z_signed);
      py_in    = 64'(dv_ff) * 64'(z_signed);
   end

   always_ff @(posedge clock) begin
      if (stage_rdy[2]) begin
         z2_ff <= z2_in;
         px_ff <= px_in;
         py_ff <= py_in;
      end
   end

   // ------------------------------------------------------------------
   // Stage 3: round to Q.16, split 1/f into two 16-bit partial products
   // ------------------------------------------------------------------
   logic signed [63:0] pxr, pyr;
   logic signed [47:0] pzx, pzy;
   logic signed [63:0] ax_ff, ax_in, bx_ff, bx_in, ay_ff, ay_in, by_ff, by_in;
   logic [30:0]        z3_ff;

   always_comb begin
      pxr   = px_ff + 64'sd32768;
      pyr   = py_ff + 64'sd32768;
      pzx   = $signed(pxr[63:16]);
      pzy   = $signed(pyr[63:16]);
      ax_in = 64'(pzx) * 64'($signed({1'b0, inv_focal_pair_ff[31:16]}));
      bx_in = 64'(pzx) * 64'($signed({1'b0, inv_focal_pair_ff[15:0]}));
      ay_in = 64'(pzy) * 64'($signed({1'b0, inv_focal_pair_ff[63:48]}));
      by_in = 64'(pzy) * 64'($signed({1'b0, inv_focal_pair_ff[47:32]}));
   end

   always_ff @(posedge clock) begin
      if (stage_rdy[3]) begin
         ax_ff <= ax_in;
         bx_ff <= bx_in;
         ay_ff <= ay_in;
         by_ff <= by_in;
         z3_ff <= z2_ff;
      end
   end

   // ------------------------------------------------------------------
   // Stage 4: combine partial products, subtract translation, clamp
   // ------------------------------------------------------------------
   function automatic dpw_pkg::diff_type clamp_diff(logic signed [48:0] v);
      dpw_pkg::diff_type r;
      if (v > 49'sd549755813887) begin
         r = 40'sh7F_FFFF_FFFF;
      end else if (v < -49'sd549755813888) begin
         r = 40'sh80_0000_0000;
      end else begin
         r = v[39:0];
      end
      return r;
   endfunction

   logic signed [63:0] xsum, ysum;
   logic signed [47:0] xlat, ylat;
   logic signed [48:0] dx_full, dy_full, dz_full;
   dpw_pkg::coef_type  tx, ty, tz;
   dpw_pkg::diff_type  diff_ff [3];
   dpw_pkg::diff_type  diff_in [3];

   always_comb begin
      tx         = dpw_pkg::field21(translation_ff, 0);
      ty         = dpw_pkg::field21(translation_ff, 1);
      tz         = dpw_pkg::field21(translation_ff, 2);
      xsum       = ax_ff + (bx_ff >>> 16) + 64'sd32768;
      ysum       = ay_ff + (by_ff >>> 16) + 64'sd32768;
      xlat       = $signed(xsum[63:16]);
      ylat       = $signed(ysum[63:16]);
      dx_full    = 49'(xlat) - 49'($signed({tx, 6'd0}));
      dy_full    = 49'(ylat) - 49'($signed({ty, 6'd0}));
      dz_full    = $signed({18'd0, z3_ff}) - 49'($signed({tz, 6'd0}));
      diff_in[0] = clamp_diff(dx_full);
      diff_in[1] = clamp_diff(dy_full);
      diff_in[2] = clamp_diff(dz_full);
   end

   always_ff @(posedge clock) begin
      if (stage_rdy[4]) begin
         diff_ff <= diff_in;
      end
   end

   // ------------------------------------------------------------------
   // Stage 5: coefficient products, one per row and column
   // ------------------------------------------------------------------
   dpw_pkg::term_type term_ff [3][3];
   dpw_pkg::term_type term_in [3][3];

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         for (int k = 0; k < 3; k++) begin
            term_in[r][k] = 61'(dpw_pkg::field21(rot_ff[r], k)) * 61'(diff_ff[k]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (stage_rdy[5]) begin
         term_ff <= term_in;
      end
   end

   // ------------------------------------------------------------------
   // Stage 6: sum, round, saturate into the output register
   // ------------------------------------------------------------------
   logic signed [62:0] acc   [3];
   logic signed [62:0] acc_sh[3];
   dpw_pkg::point_type point_ff [3];
   dpw_pkg::point_type point_in [3];

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         acc[r]    = 63'(term_ff[r][0]) + 63'(term_ff[r][1]) + 63'(term_ff[r][2])
                   + 63'sd131072;
         acc_sh[r] = acc[r] >>> 18;
         if (acc_sh[r] > 63'sd2147483647) begin
            point_in[r] = 32'sh7FFF_FFFF;
         end else if (acc_sh[r] < -63'sd2147483648) begin
            point_in[r] = 32'sh8000_0000;
         end else begin
            point_in[r] = acc_sh[r][31:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (stage_rdy[6]) begin
         point_ff <= point_in;
      end
   end

   assign rsp_chan.valid   = valid_ff[STAGES];
   assign rsp_chan.point_x = point_ff[0];
   assign rsp_chan.point_y = point_ff[1];
   assign rsp_chan.point_z = point_ff[2];

   // ------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------
   `DPW_ASSERT_NOW(a_empty_after_reset, clock, reset, $past(reset), !rsp_chan.valid, "point valid right after reset")

   `DPW_ASSERT_NEXT(a_drop_bad_depth, clock, reset, req_chan.valid && req_chan.ready && (req_chan.depth <= 16'sd0), !valid_ff[1], "request with invalid depth entered the pipeline")

   `DPW_ASSERT_NOW(a_backpressure_full, clock, reset, !req_chan.ready, (&valid_ff) && !rsp_chan.ready, "request stalled while a stage was free")

endmodule
